// ===== hdl/rrtv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtv_pkg
// Shared types, constants and helpers for the rounded-rect vertex generator.
// ---------------------------------------------------------------------------
package rrtv_pkg;

  localparam int unsigned MAX_CORNER_POINTS_DEF = 15;
  localparam int unsigned SIZE_BITS_DEF         = 12;
  localparam int unsigned SINE_TABLE_DEPTH_DEF  = 64;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int unsigned     UNIT_Q16         = 65536;
  localparam int unsigned     RECIP_BITS       = 40;
  localparam int unsigned     DIV_NUM_W        = RECIP_BITS + 1;
  localparam int unsigned     RECIP_LO_W       = 20;

  // config register indexes
  localparam logic [2:0] CFG_FILL_MODE     = 3'd0;
  localparam logic [2:0] CFG_H_ALIGN       = 3'd1;
  localparam logic [2:0] CFG_V_ALIGN       = 3'd2;
  localparam logic [2:0] CFG_CORNER_RADIUS = 3'd3;
  localparam logic [2:0] CFG_CORNER_POINTS = 3'd4;

  localparam logic [2:0] FM_FIT  = 3'd1;
  localparam logic [2:0] FM_CROP = 3'd2;

  localparam logic [1:0] AL_LEFT  = 2'd0;
  localparam logic [1:0] AL_RIGHT = 2'd2;

  typedef struct packed {
    logic [2:0]  fill_mode;
    logic [1:0]  h_align;
    logic [1:0]  v_align;
    logic [15:0] corner_radius;
    logic [3:0]  corner_points;
  } cfg_t;

  typedef enum logic [1:0] {VK_CENTER, VK_TOP, VK_ARC, VK_LAST} vkind_t;
  typedef enum logic [1:0] {DS_SCALE, DS_RU, DS_RV, DS_STEP} div_sel_t;

  typedef struct packed {
    logic     load;
    logic     prep;
    logic     div_start;
    div_sel_t div_sel;
    logic     frame;
    logic     arc_reset;
    logic     arc_adv;
    logic     st_look;
    logic     st_interp;
    logic     st_sine;
    logic     st_offs;
    logic     st_pos;
    logic     st_mul;
    logic     st_out;
    vkind_t   vkind;
    logic [1:0] corner;
    logic [3:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  function automatic logic [3:0] clamp_points(input logic [3:0] cp, input logic [3:0] maxp);
    logic [3:0] c;
    c = cp;
    if (c < 4'd2) c = 4'd2;
    if (c > maxp) c = maxp;
    return c;
  endfunction

  // Q1.16 sine of a Q2.30 angle, odd Taylor terms up to x^15 (elaboration only)
  function automatic logic [16:0] sine_entry(input longint unsigned x);
    longint unsigned t;
    longint          sum;
    longint unsigned e;
    bit              neg;
    t   = x;
    sum = $signed(x);
    neg = 1'b1;
    for (int n = 3; n <= 15; n += 2) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((n - 1) * n);
      if (neg) sum = sum - $signed(t);
      else     sum = sum + $signed(t);
      neg = !neg;
    end
    if (sum < 0) e = 64'd0;
    else         e = ($unsigned(sum) + 64'd8192) >> 14;
    return (e > 64'd65536) ? 17'd65536 : e[16:0];
  endfunction

endpackage

// ===== hdl/rrtv_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtv_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rrtv_div #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 29
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
        cnt_r  <= CW'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/rrtv_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtv_dp
// Datapath: frame setup, reciprocals, arc sine/cosine and vertex math.
// ---------------------------------------------------------------------------
module rrtv_dp import rrtv_pkg::*; #(
  parameter int unsigned SIZE_BITS        = SIZE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [SIZE_BITS-1:0] item_width,
  input  logic [SIZE_BITS-1:0] item_height,
  input  logic [SIZE_BITS-1:0] image_width,
  input  logic [SIZE_BITS-1:0] image_height,
  output logic [15:0]          pos_x,
  output logic [15:0]          pos_y,
  output logic [16:0]          tex_u,
  output logic [16:0]          tex_v,
  output logic                 last_vertex
);

  localparam int unsigned SB   = SIZE_BITS;
  localparam int unsigned FW   = 2 * SB + 6;
  localparam int unsigned XW   = FW + 1;
  localparam int unsigned DW   = 2 * SB + 4;
  localparam int unsigned DSW  = 2 * SB + 5;
  localparam int unsigned IW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PW   = IW + 16;
  localparam int unsigned RHW  = DIV_NUM_W - RECIP_LO_W;
  localparam int unsigned SW   = DW + DIV_NUM_W + 1;
  localparam logic [PW-1:0] ANG_MAX = PW'(SINE_TABLE_DEPTH) << 16;
  localparam logic [IW-1:0] IDX_MAX = IW'(SINE_TABLE_DEPTH);

  typedef struct packed {
    logic [16:0] a;
    logic [16:0] d;
    logic [15:0] f;
  } lut_t;

  // ---- sine table ----
  logic [16:0] sine_rom [0:SINE_TABLE_DEPTH];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sine
    localparam longint unsigned ANG = (QUARTER_TURN_Q30 * 64'(g)) / SINE_TABLE_DEPTH;
    assign sine_rom[g] = sine_entry(ANG);
  end

  function automatic lut_t lookup(input logic [PW-1:0] p);
    lut_t        l;
    logic [IW-1:0] idx;
    logic [16:0] b;
    idx = p[PW-1:16];
    if (idx >= IDX_MAX) begin
      l.a = sine_rom[IDX_MAX];
      l.d = '0;
      l.f = '0;
    end else begin
      l.a = sine_rom[idx];
      b   = sine_rom[idx + IW'(1)];
      l.d = (b < l.a) ? 17'd0 : 17'(b - l.a);
      l.f = p[15:0];
    end
    return l;
  endfunction

  function automatic logic signed [FW-1:0] place(input logic signed [FW-1:0] slack,
                                                 input logic [1:0] al);
    if (slack <= 0 || al == AL_LEFT) return '0;
    if (al == AL_RIGHT) return slack;
    return slack >>> 1;
  endfunction

  // ---- request registers ----
  logic [SB-1:0]   w_r, h_r, wi_r, hi_r;
  logic [2*SB-1:0] pa_r, pb_r;
  logic signed [FW-1:0] sc_r;
  logic signed [FW-1:0] px0_r, py0_r, pw_r, ph_r, tx0_r, ty0_r, tw_r, th_r;
  logic [DIV_NUM_W-1:0] ru_r, rv_r;
  logic [PW-1:0] step_r, pos_r;
  logic [3:0]    srem_r, prem_r;

  logic tall, need_w;
  assign tall   = pa_r < pb_r;
  assign need_w = (cfg.fill_mode == FM_FIT && tall) || (cfg.fill_mode == FM_CROP && !tall);

  // ---- divider ----
  logic [DIV_NUM_W-1:0] div_num, div_q;
  logic [DSW-1:0]       div_den, div_rem;
  logic                 div_done;
  logic [2*SB-1:0]      sc_num;
  logic [SB-1:0]        sc_den;
  logic [3:0]           cnt_m1;

  assign sc_num = need_w ? pa_r : pb_r;
  assign sc_den = need_w ? hi_r : wi_r;
  assign cnt_m1 = cmd.cnt - 4'd1;

  always_comb begin
    case (cmd.div_sel)
      DS_SCALE: begin
        div_num = DIV_NUM_W'({sc_num, 5'b0}) + DIV_NUM_W'(sc_den);
        div_den = DSW'({sc_den, 1'b0});
      end
      DS_RU: begin
        div_num = DIV_NUM_W'(1) << RECIP_BITS;
        div_den = tw_r[DSW-1:0];
      end
      DS_RV: begin
        div_num = DIV_NUM_W'(1) << RECIP_BITS;
        div_den = th_r[DSW-1:0];
      end
      default: begin
        div_num = DIV_NUM_W'(ANG_MAX);
        div_den = DSW'(cnt_m1);
      end
    endcase
  end

  rrtv_div #(.NUM_W(DIV_NUM_W), .DEN_W(DSW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign sts.div_done = div_done;

  // ---- frame setup ----
  logic signed [FW-1:0] w16, h16;
  assign w16 = $signed(FW'({w_r, 4'b0}));
  assign h16 = $signed(FW'({h_r, 4'b0}));

  // ---- vertex pipeline registers ----
  lut_t        ls_r, lc_r;
  logic [32:0] sp_r, cp_r;
  logic [16:0] oms_r, omc_r;
  logic [16:0] os_r, oc_r;
  logic signed [FW-1:0] x_r, y_r;
  logic        uz_r, uf_r, vz_r, vf_r;
  logic [DW+RECIP_LO_W-1:0] mul_lo_r, mvl_r;
  logic [DW+RHW-1:0]        mul_hi_r, mvh_r;
  logic [15:0] pos_x_r, pos_y_r;
  logic [16:0] tex_u_r, tex_v_r;
  logic        last_r;

  logic [4:0]  rsum;
  logic [17:0] s_sin, s_cos;
  logic signed [FW-1:0] left, right, top, bottom, cx, cy, oss, ocs;
  logic signed [FW-1:0] xs, ys;
  logic signed [XW-1:0] du, dv;

  assign rsum = {1'b0, prem_r} + {1'b0, srem_r};
  assign s_sin = 18'(ls_r.a) + 18'((sp_r + 33'd32768) >> 16);
  assign s_cos = 18'(lc_r.a) + 18'((cp_r + 33'd32768) >> 16);

  assign left   = px0_r;
  assign right  = px0_r + pw_r;
  assign top    = py0_r;
  assign bottom = py0_r + ph_r;
  assign cx     = px0_r + (pw_r >>> 1);
  assign cy     = py0_r + (ph_r >>> 1);
  assign oss    = $signed(FW'(os_r));
  assign ocs    = $signed(FW'(oc_r));

  always_comb begin
    xs = cx;
    ys = top;
    case (cmd.vkind)
      VK_CENTER: begin
        xs = cx;
        ys = cy;
      end
      VK_ARC: begin
        case (cmd.corner)
          2'd0: begin xs = left + oss;  ys = top + ocs;    end
          2'd1: begin xs = left + ocs;  ys = bottom - oss; end
          2'd2: begin xs = right - oss; ys = bottom - ocs; end
          default: begin xs = right - ocs; ys = top + oss; end
        endcase
      end
      default: begin
        xs = cx;
        ys = top;
      end
    endcase
  end

  assign du = XW'(x_r) - XW'(tx0_r);
  assign dv = XW'(y_r) - XW'(ty0_r);

  function automatic logic [15:0] sat_pos(input logic signed [FW-1:0] p);
    if (p < 0) return 16'd0;
    if (p > $signed(FW'(65535))) return 16'hFFFF;
    return p[15:0];
  endfunction

  function automatic logic [16:0] tex_out(input logic z, input logic f,
                                          input logic [DW+RHW-1:0] hi,
                                          input logic [DW+RECIP_LO_W-1:0] lo);
    logic [SW-1:0] su;
    logic [SW-25:0] v;
    su = (SW'(hi) << RECIP_LO_W) + SW'(lo) + (SW'(1) << 23);
    v  = su[SW-1:24];
    if (z) return 17'd0;
    if (f) return 17'(UNIT_Q16);
    if (v > (SW-24)'(UNIT_Q16)) return 17'(UNIT_Q16);
    return v[16:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r  <= (item_width   == '0) ? SB'(1) : item_width;
      h_r  <= (item_height  == '0) ? SB'(1) : item_height;
      wi_r <= (image_width  == '0) ? SB'(1) : image_width;
      hi_r <= (image_height == '0) ? SB'(1) : image_height;
    end
    if (cmd.prep) begin
      pa_r <= h_r * wi_r;
      pb_r <= w_r * hi_r;
    end
    if (div_done) begin
      case (cmd.div_sel)
        DS_SCALE: sc_r <= (div_q == '0) ? FW'(1) : $signed(div_q[FW-1:0]);
        DS_RU:    ru_r <= div_q;
        DS_RV:    rv_r <= div_q;
        default: begin
          step_r <= div_q[PW-1:0];
          srem_r <= div_rem[3:0];
        end
      endcase
    end
    if (cmd.frame) begin
      px0_r <= '0; py0_r <= '0; pw_r <= w16; ph_r <= h16;
      tx0_r <= '0; ty0_r <= '0; tw_r <= w16; th_r <= h16;
      if (cfg.fill_mode == FM_FIT) begin
        if (tall) begin
          pw_r  <= sc_r;  px0_r <= place(w16 - sc_r, cfg.h_align);
          tw_r  <= sc_r;  tx0_r <= place(w16 - sc_r, cfg.h_align);
        end else begin
          ph_r  <= sc_r;  py0_r <= place(h16 - sc_r, cfg.v_align);
          th_r  <= sc_r;  ty0_r <= place(h16 - sc_r, cfg.v_align);
        end
      end else if (cfg.fill_mode == FM_CROP) begin
        if (tall) begin
          th_r  <= sc_r;  ty0_r <= -place(sc_r - h16, cfg.v_align);
        end else begin
          tw_r  <= sc_r;  tx0_r <= -place(sc_r - w16, cfg.h_align);
        end
      end
    end
    if (cmd.arc_reset) begin
      pos_r  <= '0;
      prem_r <= '0;
    end else if (cmd.arc_adv) begin
      if (rsum >= {1'b0, cnt_m1}) begin
        prem_r <= 4'(rsum - {1'b0, cnt_m1});
        pos_r  <= pos_r + step_r + PW'(1);
      end else begin
        prem_r <= rsum[3:0];
        pos_r  <= pos_r + step_r;
      end
    end
    if (cmd.st_look) begin
      ls_r <= lookup(pos_r);
      lc_r <= lookup(ANG_MAX - pos_r);
    end
    if (cmd.st_interp) begin
      sp_r <= ls_r.d * ls_r.f;
      cp_r <= lc_r.d * lc_r.f;
    end
    if (cmd.st_sine) begin
      oms_r <= 17'(18'(UNIT_Q16) - s_sin);
      omc_r <= 17'(18'(UNIT_Q16) - s_cos);
    end
    if (cmd.st_offs) begin
      os_r <= 17'((34'(cfg.corner_radius) * 34'(oms_r) + 34'd32768) >> 16);
      oc_r <= 17'((34'(cfg.corner_radius) * 34'(omc_r) + 34'd32768) >> 16);
    end
    if (cmd.st_pos) begin
      x_r <= xs;
      y_r <= ys;
    end
    if (cmd.st_mul) begin
      uz_r     <= du <= 0;
      uf_r     <= du >= XW'(tw_r);
      vz_r     <= dv <= 0;
      vf_r     <= dv >= XW'(th_r);
      mul_lo_r <= du[DW-1:0] * ru_r[RECIP_LO_W-1:0];
      mul_hi_r <= du[DW-1:0] * ru_r[DIV_NUM_W-1:RECIP_LO_W];
      mvl_r    <= dv[DW-1:0] * rv_r[RECIP_LO_W-1:0];
      mvh_r    <= dv[DW-1:0] * rv_r[DIV_NUM_W-1:RECIP_LO_W];
    end
    if (cmd.st_out) begin
      pos_x_r <= sat_pos(x_r);
      pos_y_r <= sat_pos(y_r);
      tex_u_r <= tex_out(uz_r, uf_r, mul_hi_r, mul_lo_r);
      tex_v_r <= tex_out(vz_r, vf_r, mvh_r, mvl_r);
      last_r  <= cmd.vkind == VK_LAST;
    end
  end

  assign pos_x       = pos_x_r;
  assign pos_y       = pos_y_r;
  assign tex_u       = tex_u_r;
  assign tex_v       = tex_v_r;
  assign last_vertex = last_r;

endmodule

// ===== hdl/rrtv_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrtv_ctrl
// Sequencer: request setup, divider runs and the per-vertex step order.
// ---------------------------------------------------------------------------
module rrtv_ctrl import rrtv_pkg::*; #(
  parameter int unsigned MAX_CORNER_POINTS = MAX_CORNER_POINTS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV_GO, S_DIV_WAIT, S_FRAME,
    S_LOOK, S_INTERP, S_SINE, S_OFFS, S_POS, S_MUL, S_OUT, S_WAIT
  } state_t;

  state_t     state_r;
  div_sel_t   sel_r;
  vkind_t     vk_r;
  logic [1:0] corner_r;
  logic [3:0] pt_r;
  logic       out_valid_r;
  logic [3:0] cnt;
  logic       xfer;

  assign cnt      = clamp_points(cfg.corner_points, 4'(MAX_CORNER_POINTS));
  assign in_stall = state_r != S_IDLE;
  assign xfer     = state_r == S_WAIT && !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.load      = state_r == S_IDLE && in_valid;
    cmd.prep      = state_r == S_PREP;
    cmd.div_start = state_r == S_DIV_GO;
    cmd.div_sel   = sel_r;
    cmd.frame     = state_r == S_FRAME;
    cmd.st_look   = state_r == S_LOOK;
    cmd.st_interp = state_r == S_INTERP;
    cmd.st_sine   = state_r == S_SINE;
    cmd.st_offs   = state_r == S_OFFS;
    cmd.st_pos    = state_r == S_POS;
    cmd.st_mul    = state_r == S_MUL;
    cmd.st_out    = state_r == S_OUT;
    cmd.vkind     = vk_r;
    cmd.corner    = corner_r;
    cmd.cnt       = cnt;
    // next arc angle is set up while the current vertex transfers
    cmd.arc_reset = xfer && (vk_r == VK_TOP ||
                    (vk_r == VK_ARC && pt_r == cnt - 4'd1));
    cmd.arc_adv   = xfer && vk_r == VK_ARC && pt_r != cnt - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= DS_SCALE;
      vk_r        <= VK_CENTER;
      corner_r    <= '0;
      pt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_PREP;
        S_PREP: begin
          sel_r   <= DS_SCALE;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            unique case (sel_r)
              DS_SCALE: state_r <= S_FRAME;
              DS_RU: begin
                sel_r   <= DS_RV;
                state_r <= S_DIV_GO;
              end
              DS_RV: begin
                sel_r   <= DS_STEP;
                state_r <= S_DIV_GO;
              end
              default: begin
                vk_r    <= VK_CENTER;
                state_r <= S_LOOK;
              end
            endcase
          end
        end
        S_FRAME: begin
          sel_r   <= DS_RU;
          state_r <= S_DIV_GO;
        end
        S_LOOK:   state_r <= S_INTERP;
        S_INTERP: state_r <= S_SINE;
        S_SINE:   state_r <= S_OFFS;
        S_OFFS:   state_r <= S_POS;
        S_POS:    state_r <= S_MUL;
        S_MUL:    state_r <= S_OUT;
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= (vk_r == VK_LAST) ? S_IDLE : S_LOOK;
            unique case (vk_r)
              VK_CENTER: vk_r <= VK_TOP;
              VK_TOP: begin
                vk_r     <= VK_ARC;
                corner_r <= '0;
                pt_r     <= '0;
              end
              VK_ARC: begin
                if (pt_r == cnt - 4'd1) begin
                  pt_r <= '0;
                  if (corner_r == 2'd3) vk_r <= VK_LAST;
                  else corner_r <= corner_r + 2'd1;
                end else begin
                  pt_r <= pt_r + 4'd1;
                end
              end
              default: ;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/rounded_rect_textured_vertex_gen.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rounded_rect_textured_vertex_gen
// Triangle-fan vertex generator for a textured rectangle with rounded corners.
//
// One input transfer (item and image size) yields a fan of 4*N+3 vertices,
// N = corner_points clamped to 2..MAX_CORNER_POINTS: center, top middle, four
// corner arcs, then top middle again flagged with last_vertex.
// Config writes (cfg_valid/cfg_ready, always ready) must go in while idle; the block does not enforce it.
// Setup forms the aspect products, then runs four serial divisions in the
// shared divider (aspect scale, two texture reciprocals, arc step), with the
// frame placed after the aspect scale. Each vertex then steps through the
// shared sine/multiply datapath: lookup, interpolate, sine, offset, position,
// multiply and output.
// in_stall is high from the accepted request until its last vertex transfers.
// While out_stall is high the vertex held in the output register stays put
// and the sequencer waits. Reset returns to idle and loads the register
// defaults: stretch, centered, radius 0, 4 points per arc.
// ---------------------------------------------------------------------------
module rounded_rect_textured_vertex_gen import rrtv_pkg::*; #(
  parameter int unsigned MAX_CORNER_POINTS = MAX_CORNER_POINTS_DEF,
  parameter int unsigned SIZE_BITS         = SIZE_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH  = SINE_TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SIZE_BITS-1:0] in_item_width,
  input  logic [SIZE_BITS-1:0] in_item_height,
  input  logic [SIZE_BITS-1:0] in_image_width,
  input  logic [SIZE_BITS-1:0] in_image_height,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_pos_x,
  output logic [15:0]          out_pos_y,
  output logic [16:0]          out_tex_u,
  output logic [16:0]          out_tex_v,
  output logic                 out_last_vertex
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fill_mode     <= 3'd0;
      cfg_r.h_align       <= 2'd1;
      cfg_r.v_align       <= 2'd1;
      cfg_r.corner_radius <= 16'd0;
      cfg_r.corner_points <= 4'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FILL_MODE:     cfg_r.fill_mode     <= cfg_data[2:0];
        CFG_H_ALIGN:       cfg_r.h_align       <= cfg_data[1:0];
        CFG_V_ALIGN:       cfg_r.v_align       <= cfg_data[1:0];
        CFG_CORNER_RADIUS: cfg_r.corner_radius <= cfg_data;
        CFG_CORNER_POINTS: cfg_r.corner_points <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  rrtv_ctrl #(.MAX_CORNER_POINTS(MAX_CORNER_POINTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrtv_dp #(
    .SIZE_BITS        (SIZE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts),
    .item_width   (in_item_width),
    .item_height  (in_item_height),
    .image_width  (in_image_width),
    .image_height (in_image_height),
    .pos_x        (out_pos_x),
    .pos_y        (out_pos_y),
    .tex_u        (out_tex_u),
    .tex_v        (out_tex_v),
    .last_vertex  (out_last_vertex)
  );

endmodule
